[design/rhr_pkg.sv]
// shared types, constants and stage numbering for the rgb/hsi round trip pipeline
package rhr_pkg;

  localparam int PIXEL_BITS    = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int INT_FRAC_BITS = 6;
  localparam int ANG_BITS      = 16;
  localparam int CORDIC_STEPS  = 20;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int SQRT3_Q16     = 113512;
  localparam int ROT_START     = 1 << 24;

  localparam int CW   = 28;
  localparam int ZW   = 26;
  localparam int DIVW = 32;
  localparam int DQW  = 64;

  localparam int SAT_QBITS = 16;
  localparam int C2_QBITS  = 27;

  typedef logic signed [CW-1:0] cxy_t;
  typedef logic signed [ZW-1:0] cz_t;

  localparam cz_t ATAN_TAB [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
    26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
    26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
  };

  // pipeline stage numbers (register index of each step)
  localparam int ST_IN   = 0;
  localparam int ST_PREP = 1;
  localparam int ST_SAT  = ST_PREP + SAT_QBITS + 1;
  localparam int ST_HUE  = ST_PREP + CORDIC_STEPS + 1;
  localparam int ST_C    = ST_HUE + CORDIC_STEPS + 1;
  localparam int ST_N    = ST_C + 1;
  localparam int ST_D    = ST_N + 1;
  localparam int ST_Q    = ST_D + C2_QBITS + 1;
  localparam int ST_PIX  = ST_Q + 1;

  typedef struct packed {
    logic             vec;
    logic [STEP_W-1:0] step;
  } cord_ctl_t;

  typedef struct packed {
    cxy_t x;
    cxy_t y;
    cz_t  z;
  } cord_t;

  typedef struct packed {
    logic [DIVW-1:0] rem;
    logic [DIVW-1:0] dv;
    logic [DQW-1:0]  dq;
  } div_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] r;
    logic [PIXEL_BITS-1:0] g;
    logic [PIXEL_BITS-1:0] b;
    logic [13:0]           inten;
    logic                  gray;
    logic                  geqb;
    logic                  xvz;
    logic                  xneg;
    logic                  bgtg;
    logic [15:0]           sat;
    logic [14:0]           hue;
    logic [1:0]            sector;
    logic                  hp0;
    logic [24:0]           c1f;
    logic                  dneg;
  } side_t;

endpackage

[design/rhr_cordic_cell.sv]
// one cordic micro-rotation cell, vectoring or rotation mode
module rhr_cordic_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  rhr_pkg::cord_ctl_t ctl_i,
  input  rhr_pkg::cord_t     cell_i,
  output rhr_pkg::cord_t     cell_o
);

  rhr_pkg::cord_t  cell_d, cell_q;
  rhr_pkg::cxy_t   dx, dy;
  logic            plus;

  always_comb begin
    dx   = cell_i.y >>> ctl_i.step;
    dy   = cell_i.x >>> ctl_i.step;
    plus = ctl_i.vec ? ~cell_i.y[rhr_pkg::CW-1] : cell_i.z[rhr_pkg::ZW-1];
    if (plus) begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + rhr_pkg::ATAN_TAB[ctl_i.step];
    end else begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - rhr_pkg::ATAN_TAB[ctl_i.step];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[design/rhr_div_cell.sv]
// one restoring division step cell
module rhr_div_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  rhr_pkg::div_t cell_i,
  output rhr_pkg::div_t cell_o
);

  rhr_pkg::div_t           cell_d, cell_q;
  logic [rhr_pkg::DIVW:0]  t;
  logic [rhr_pkg::DIVW:0]  diff;
  logic                    ge;

  always_comb begin
    t            = {cell_i.rem, cell_i.dq[rhr_pkg::DQW-1]};
    diff         = t - {1'b0, cell_i.dv};
    ge           = t >= {1'b0, cell_i.dv};
    cell_d.dv    = cell_i.dv;
    cell_d.rem   = ge ? diff[rhr_pkg::DIVW-1:0] : t[rhr_pkg::DIVW-1:0];
    cell_d.dq    = {cell_i.dq[rhr_pkg::DQW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[design/rgb_hsi_round_trip.sv]
// rgb to hsi conversion and reconstruction, one pixel per cycle pipeline
// throughput: one word per cycle, set by the cordic and divider cell rows
// the pipeline stalls only while the output register holds an untaken word
// and the last stage is full; reset clears the valid line, not the data
module rgb_hsi_round_trip (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // hue, saturation, intensity, back_red,
                                     // back_green, back_blue, pixel_error
);

  localparam int HSH = rhr_pkg::ANG_BITS - rhr_pkg::HUE_FRAC_BITS;
  localparam int C1SH = rhr_pkg::INT_FRAC_BITS + 15 - rhr_pkg::ANG_BITS;
  localparam logic [24:0] ANG60  = 25'(60 * (1 << rhr_pkg::ANG_BITS));
  localparam logic [24:0] ANG90  = 25'(90 * (1 << rhr_pkg::ANG_BITS));
  localparam logic [24:0] ANG180 = 25'(180 * (1 << rhr_pkg::ANG_BITS));
  localparam logic [24:0] ANG360 = 25'(360 * (1 << rhr_pkg::ANG_BITS));
  localparam logic [14:0] HUE_FULL  = 15'(360 << rhr_pkg::HUE_FRAC_BITS);
  localparam logic [14:0] HUE_THIRD = 15'(120 << rhr_pkg::HUE_FRAC_BITS);
  localparam logic [1:0] SEC_RG = 2'd0;
  localparam logic [1:0] SEC_GB = 2'd1;
  localparam logic [1:0] SEC_BR = 2'd2;
  localparam logic signed [18:0] SQ3 = 19'(rhr_pkg::SQRT3_Q16);

  logic en_pipe, out_load;
  logic [rhr_pkg::ST_PIX:0] vld_q;
  logic out_vld_q;

  rhr_pkg::side_t side_d [0:rhr_pkg::ST_PIX];
  rhr_pkg::side_t side_q [0:rhr_pkg::ST_PIX];

  // stage registers
  rhr_pkg::cord_t vin_d, vin_q, rin_d, rin_q;
  rhr_pkg::div_t  sdin_d, sdin_q, cdin;
  rhr_pkg::cxy_t  c_d, c_q, num_d, num_q, cn_q, c2f_d, c2f_q;
  logic signed [45:0] n_d, n_q;
  logic signed [60:0] d_d, d_q;
  logic [31:0]        dv_d, dv_q;
  logic [7:0] br_d, br_q, bg_d, bg_q, bb_d, bb_q;

  rhr_pkg::cord_t vec_in [rhr_pkg::CORDIC_STEPS];
  rhr_pkg::cord_t vec_q  [rhr_pkg::CORDIC_STEPS];
  rhr_pkg::cord_t rot_in [rhr_pkg::CORDIC_STEPS];
  rhr_pkg::cord_t rot_q  [rhr_pkg::CORDIC_STEPS];
  rhr_pkg::div_t  sdiv_in [rhr_pkg::SAT_QBITS];
  rhr_pkg::div_t  sdiv_q  [rhr_pkg::SAT_QBITS];
  rhr_pkg::div_t  cdiv_in [rhr_pkg::C2_QBITS];
  rhr_pkg::div_t  cdiv_q  [rhr_pkg::C2_QBITS];

  // output word registers
  logic [14:0] o_hue_q;
  logic [15:0] o_sat_q;
  logic [13:0] o_int_q;
  logic [7:0]  o_br_q, o_bg_q, o_bb_q;
  logic [9:0]  o_err_q;

  // prep temporaries
  logic [7:0]  p_r, p_g, p_b, p_mn, p_agb;
  logic [9:0]  p_sum, p_smn3, p_axv;
  logic [15:0] p_v;
  logic [32:0] p_prod;
  logic signed [10:0] p_xv;
  logic [24:0] p_vy;

  // hue temporaries
  rhr_pkg::cz_t h_z;
  logic [24:0] h_a, h_ang1, h_ang, h_rnd;
  logic [14:0] h_hr, h_hue;
  logic [1:0]  h_sec;
  logic [12:0] h_hp;

  // back conversion temporaries
  logic signed [46:0] c_prod;
  logic [29:0] c1_prod;
  logic [59:0] dm;
  logic [26:0] q_mag;
  rhr_pkg::cxy_t q_ext, c1s, c3f, i3;
  logic [7:0] px1, px2, px3, e0, e1, e2;

  function automatic logic [7:0] to_pix(input rhr_pkg::cxy_t v);
    rhr_pkg::cxy_t t;
    begin
      t = (v + rhr_pkg::cxy_t'(1 << (rhr_pkg::ANG_BITS - 1))) >>> rhr_pkg::ANG_BITS;
      if (t < 0) begin
        return 8'd0;
      end else if (t > rhr_pkg::cxy_t'((1 << rhr_pkg::PIXEL_BITS) - 1)) begin
        return 8'hff;
      end else begin
        return t[7:0];
      end
    end
  endfunction

  assign out_load      = ~out_vld_q | m_axis_tready;
  assign en_pipe       = out_load | ~vld_q[rhr_pkg::ST_PIX];
  assign s_axis_tready = en_pipe;

  // prep stage
  always_comb begin
    p_r    = side_q[rhr_pkg::ST_IN].r;
    p_g    = side_q[rhr_pkg::ST_IN].g;
    p_b    = side_q[rhr_pkg::ST_IN].b;
    p_sum  = {2'b0, p_r} + {2'b0, p_g} + {2'b0, p_b};
    p_mn   = p_r;
    if (p_g < p_mn) p_mn = p_g;
    if (p_b < p_mn) p_mn = p_b;
    p_v    = {p_sum, 6'b0} + 16'd1;
    p_prod = {17'b0, p_v} * 33'd43691;
    p_xv   = $signed({2'b0, p_r, 1'b0}) - $signed({3'b0, p_g}) - $signed({3'b0, p_b});
    p_axv  = p_xv[10] ? 10'(-p_xv) : p_xv[9:0];
    p_agb  = (p_g > p_b) ? (p_g - p_b) : (p_b - p_g);
    p_vy   = {17'b0, p_agb} * 25'(rhr_pkg::SQRT3_Q16);
    p_smn3 = p_sum - ({2'b0, p_mn} + {1'b0, p_mn, 1'b0});
    vin_d.x = {2'b0, p_axv, 16'b0};
    vin_d.y = {3'b0, p_vy};
    vin_d.z = '0;
    sdin_d.rem = {22'b0, p_smn3};
    sdin_d.dv  = {21'b0, p_sum, 1'b0};
    sdin_d.dq  = {6'b0, p_sum, 48'b0};
  end

  // hue stage
  always_comb begin
    h_z = vec_q[rhr_pkg::CORDIC_STEPS-1].z;
    if (side_q[rhr_pkg::ST_HUE-1].geqb) begin
      h_a = '0;
    end else if (side_q[rhr_pkg::ST_HUE-1].xvz) begin
      h_a = ANG90;
    end else if (h_z < 0) begin
      h_a = '0;
    end else if (h_z > rhr_pkg::cz_t'(ANG90)) begin
      h_a = ANG90;
    end else begin
      h_a = h_z[24:0];
    end
    h_ang1 = side_q[rhr_pkg::ST_HUE-1].xneg ? (ANG180 - h_a) : h_a;
    h_ang  = side_q[rhr_pkg::ST_HUE-1].bgtg ? (ANG360 - h_ang1) : h_ang1;
    h_rnd  = h_ang + 25'(1 << (HSH - 1));
    h_hr   = 15'(h_rnd >> HSH);
    if (side_q[rhr_pkg::ST_HUE-1].gray) begin
      h_hue = '0;
    end else if (h_hr >= HUE_FULL) begin
      h_hue = h_hr - HUE_FULL;
    end else begin
      h_hue = h_hr;
    end
    if (h_hue >= 15'(2 * HUE_THIRD)) begin
      h_sec = SEC_BR;
      h_hp  = 13'(h_hue - 15'(2 * HUE_THIRD));
    end else if (h_hue >= HUE_THIRD) begin
      h_sec = SEC_GB;
      h_hp  = 13'(h_hue - HUE_THIRD);
    end else begin
      h_sec = SEC_RG;
      h_hp  = 13'(h_hue);
    end
    rin_d.x = rhr_pkg::cxy_t'(rhr_pkg::ROT_START);
    rin_d.y = '0;
    rin_d.z = (rhr_pkg::cz_t'(h_hp) <<< HSH) - rhr_pkg::cz_t'(ANG60);
  end

  // cosine ratio terms
  always_comb begin
    if (side_q[rhr_pkg::ST_C-1].hp0) begin
      c_d = rhr_pkg::cxy_t'(rhr_pkg::ROT_START);
    end else if (rot_q[rhr_pkg::CORDIC_STEPS-1].x > 0) begin
      c_d = rot_q[rhr_pkg::CORDIC_STEPS-1].x;
    end else begin
      c_d = rhr_pkg::cxy_t'(1);
    end
    c_prod = rot_q[rhr_pkg::CORDIC_STEPS-1].y * SQ3;
    num_d  = side_q[rhr_pkg::ST_C-1].hp0 ? (c_d <<< 2)
                                          : (c_d - rhr_pkg::cxy_t'(c_prod >>> 16));
    c1_prod = {16'b0, side_q[rhr_pkg::ST_C-1].inten}
            * {14'b0, 16'd32768 - side_q[rhr_pkg::ST_C-1].sat};
    n_d  = (46'(c_q) <<< 16) + ($signed({1'b0, side_q[rhr_pkg::ST_N-1].sat}) * num_q);
    d_d  = $signed({1'b0, side_q[rhr_pkg::ST_D-1].inten}) * n_q;
    dv_d = {cn_q[25:0], 6'b0};
    dm   = d_q[60] ? 60'(-d_q) : d_q[59:0];
    cdin.rem = dm[58:27];
    cdin.dv  = dv_q;
    cdin.dq  = {dm[26:0], 37'b0};
  end

  // quotient sign fix, third component, pixel rounding and per-channel errors
  always_comb begin
    q_mag = cdiv_q[rhr_pkg::C2_QBITS-1].dq[26:0];
    q_ext = rhr_pkg::cxy_t'(q_mag);
    c2f_d = side_q[rhr_pkg::ST_Q-1].dneg
          ? -(q_ext + rhr_pkg::cxy_t'(|cdiv_q[rhr_pkg::C2_QBITS-1].rem))
          : q_ext;
    i3  = rhr_pkg::cxy_t'({side_q[rhr_pkg::ST_PIX-1].inten, 10'b0})
        + rhr_pkg::cxy_t'({side_q[rhr_pkg::ST_PIX-1].inten, 11'b0});
    c1s = rhr_pkg::cxy_t'(side_q[rhr_pkg::ST_PIX-1].c1f);
    c3f = i3 - c1s - c2f_q;
    px1 = to_pix(c1s);
    px2 = to_pix(c2f_q);
    px3 = to_pix(c3f);
    case (side_q[rhr_pkg::ST_PIX-1].sector)
      SEC_RG: begin
        bb_d = px1; br_d = px2; bg_d = px3;
      end
      SEC_GB: begin
        br_d = px1; bg_d = px2; bb_d = px3;
      end
      default: begin
        bg_d = px1; bb_d = px2; br_d = px3;
      end
    endcase
    e0 = (side_q[rhr_pkg::ST_PIX].r > br_q) ? side_q[rhr_pkg::ST_PIX].r - br_q
                                           : br_q - side_q[rhr_pkg::ST_PIX].r;
    e1 = (side_q[rhr_pkg::ST_PIX].g > bg_q) ? side_q[rhr_pkg::ST_PIX].g - bg_q
                                           : bg_q - side_q[rhr_pkg::ST_PIX].g;
    e2 = (side_q[rhr_pkg::ST_PIX].b > bb_q) ? side_q[rhr_pkg::ST_PIX].b - bb_q
                                           : bb_q - side_q[rhr_pkg::ST_PIX].b;
  end

  // side line
  always_comb begin
    side_d[0]   = '0;
    side_d[0].r = s_axis_tdata[7:0];
    side_d[0].g = s_axis_tdata[15:8];
    side_d[0].b = s_axis_tdata[23:16];
    for (int k = 1; k <= rhr_pkg::ST_PIX; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[rhr_pkg::ST_PREP].inten = p_prod[30:17];
    side_d[rhr_pkg::ST_PREP].gray  = (p_r == p_g) && (p_r == p_b);
    side_d[rhr_pkg::ST_PREP].geqb  = p_g == p_b;
    side_d[rhr_pkg::ST_PREP].xvz   = p_xv == 11'sd0;
    side_d[rhr_pkg::ST_PREP].xneg  = p_xv[10];
    side_d[rhr_pkg::ST_PREP].bgtg  = p_b > p_g;
    side_d[rhr_pkg::ST_SAT].sat    = sdiv_q[rhr_pkg::SAT_QBITS-1].dq[15:0];
    side_d[rhr_pkg::ST_HUE].hue    = h_hue;
    side_d[rhr_pkg::ST_HUE].sector = h_sec;
    side_d[rhr_pkg::ST_HUE].hp0    = h_hp == 13'd0;
    side_d[rhr_pkg::ST_HUE].sat    = side_q[rhr_pkg::ST_HUE-1].gray
                                   ? 16'd0 : side_q[rhr_pkg::ST_HUE-1].sat;
    side_d[rhr_pkg::ST_C].c1f      = 25'(c1_prod >> C1SH);
    side_d[rhr_pkg::ST_D+1].dneg   = d_q[60];
  end

  for (genvar k = 0; k < rhr_pkg::CORDIC_STEPS; k++) begin : g_cordic
    if (k == 0) begin : g_first
      assign vec_in[k] = vin_q;
      assign rot_in[k] = rin_q;
    end else begin : g_next
      assign vec_in[k] = vec_q[k-1];
      assign rot_in[k] = rot_q[k-1];
    end
    rhr_cordic_cell u_vec (
      .clk_i  (clk_i),
      .en_i   (en_pipe),
      .ctl_i  (rhr_pkg::cord_ctl_t'{vec: 1'b1, step: rhr_pkg::STEP_W'(k)}),
      .cell_i (vec_in[k]),
      .cell_o (vec_q[k])
    );
    rhr_cordic_cell u_rot (
      .clk_i  (clk_i),
      .en_i   (en_pipe),
      .ctl_i  (rhr_pkg::cord_ctl_t'{vec: 1'b0, step: rhr_pkg::STEP_W'(k)}),
      .cell_i (rot_in[k]),
      .cell_o (rot_q[k])
    );
  end

  for (genvar k = 0; k < rhr_pkg::SAT_QBITS; k++) begin : g_sdiv
    if (k == 0) begin : g_first
      assign sdiv_in[k] = sdin_q;
    end else begin : g_next
      assign sdiv_in[k] = sdiv_q[k-1];
    end
    rhr_div_cell u_div (
      .clk_i  (clk_i),
      .en_i   (en_pipe),
      .cell_i (sdiv_in[k]),
      .cell_o (sdiv_q[k])
    );
  end

  for (genvar k = 0; k < rhr_pkg::C2_QBITS; k++) begin : g_cdiv
    if (k == 0) begin : g_first
      assign cdiv_in[k] = cdin;
    end else begin : g_next
      assign cdiv_in[k] = cdiv_q[k-1];
    end
    rhr_div_cell u_div (
      .clk_i  (clk_i),
      .en_i   (en_pipe),
      .cell_i (cdiv_in[k]),
      .cell_o (cdiv_q[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en_pipe) begin
        vld_q <= {vld_q[rhr_pkg::ST_PIX-1:0], s_axis_tvalid};
      end
      if (out_load) begin
        out_vld_q <= vld_q[rhr_pkg::ST_PIX];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_pipe) begin
      side_q <= side_d;
      vin_q  <= vin_d;
      sdin_q <= sdin_d;
      rin_q  <= rin_d;
      c_q    <= c_d;
      num_q  <= num_d;
      cn_q   <= c_q;
      n_q    <= n_d;
      d_q    <= d_d;
      dv_q   <= dv_d;
      c2f_q  <= c2f_d;
      br_q   <= br_d;
      bg_q   <= bg_d;
      bb_q   <= bb_d;
    end
    if (out_load) begin
      o_hue_q <= side_q[rhr_pkg::ST_PIX].hue;
      o_sat_q <= side_q[rhr_pkg::ST_PIX].sat;
      o_int_q <= side_q[rhr_pkg::ST_PIX].inten;
      o_br_q  <= br_q;
      o_bg_q  <= bg_q;
      o_bb_q  <= bb_q;
      o_err_q <= {2'b0, e0} + {2'b0, e1} + {2'b0, e2};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, o_err_q, o_bb_q, o_bg_q, o_br_q, o_int_q, o_sat_q, o_hue_q};

endmodule

[sim/tb.sv]
// testbench for the rgb to hsi round trip pipeline
`timescale 1ns / 100ps

module tb;

  localparam int PIX_W   = 8;
  localparam int HFRAC   = 6;
  localparam int IFRAC   = 6;
  localparam int ABITS   = 16;
  localparam int NSTEPS  = 20;
  localparam longint SQ3 = 113512;
  localparam longint ROT0 = 64'd16777216;
  localparam int LATENCY = 75;

  typedef struct packed {
    logic [9:0]  err;
    logic [7:0]  bb;
    logic [7:0]  bg;
    logic [7:0]  br;
    logic [13:0] inten;
    logic [15:0] sat;
    logic [14:0] hue;
  } hsi_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  hsi_word_t   expected_q[$];
  int          fails = 0;
  int          src_idle = 0;
  int          snk_idle = 0;

  longint atan_tab [NSTEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  always #2 clk_i = ~clk_i;

  rgb_hsi_round_trip dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic longint floor_shr(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-(v + 1)) >>> k) - 1;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint to_pixel(longint vf);
    longint v;
    v = floor_shr(vf + (64'sd1 <<< (ABITS - 1)), ABITS);
    if (v < 0) v = 0;
    if (v > (64'sd1 <<< PIX_W) - 1) v = (64'sd1 <<< PIX_W) - 1;
    return v;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint vector_angle(longint ax, longint ay);
    longint x, y, z, dx, dy;
    x = ax; y = ay; z = 0;
    for (int k = 0; k < NSTEPS; k++) begin
      dx = floor_shr(y, k);
      dy = floor_shr(x, k);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[k];
      end else begin
        x -= dx; y += dy; z -= atan_tab[k];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    return z;
  endfunction

  function automatic hsi_word_t predict_round_trip(logic [7:0] r8, logic [7:0] g8,
                                                   logic [7:0] b8);
    hsi_word_t w;
    longint r, g, b, sum, mn, hue, sat, inten, hp, c, num, c1f, c2f, c3f;
    longint xv, a, ang, x, y, z, dx, dy, br, bg, bb;
    longint sector;
    r = r8; g = g8; b = b8;
    sum = r + g + b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    hue = 0; sat = 0;
    inten = (sum * (2 << IFRAC) + 3) / 6;
    if (!(r == g && r == b)) begin
      xv = 2 * r - g - b;
      if (g == b) a = 0;
      else if (xv == 0) a = 90 * 65536;
      else a = vector_angle(labs(xv) * 65536, labs(g - b) * SQ3);
      ang = (xv >= 0) ? a : 180 * 65536 - a;
      if (b > g) ang = 360 * 65536 - ang;
      hue = (ang + (64'sd1 <<< (ABITS - HFRAC - 1))) >>> (ABITS - HFRAC);
      if (hue >= (360 << HFRAC)) hue -= (360 << HFRAC);
      sat = (((sum - 3 * mn) <<< 16) + sum) / (2 * sum);
    end
    sector = hue / (120 << HFRAC);
    hp = hue - sector * (120 << HFRAC);
    if (hp == 0) begin
      c = ROT0;
      num = 4 * c;
    end else begin
      x = ROT0; y = 0;
      z = (hp <<< (ABITS - HFRAC)) - 60 * 65536;
      for (int k = 0; k < NSTEPS; k++) begin
        dx = floor_shr(y, k);
        dy = floor_shr(x, k);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[k];
        end else begin
          x += dx; y -= dy; z += atan_tab[k];
        end
      end
      c = x > 0 ? x : 1;
      num = c - floor_shr(y * SQ3, 16);
    end
    c1f = (inten * (32768 - sat)) >>> (IFRAC + 15 - ABITS);
    c2f = floor_div(inten * (2 * c * 32768 + sat * num),
                    c * (64'sd2 <<< (IFRAC + 15 - ABITS)));
    c3f = 3 * inten * (64'sd1 <<< (ABITS - IFRAC)) - c1f - c2f;
    if (sector == 0) begin
      bb = to_pixel(c1f); br = to_pixel(c2f); bg = to_pixel(c3f);
    end else if (sector == 1) begin
      br = to_pixel(c1f); bg = to_pixel(c2f); bb = to_pixel(c3f);
    end else begin
      bg = to_pixel(c1f); bb = to_pixel(c2f); br = to_pixel(c3f);
    end
    w.hue   = hue[14:0];
    w.sat   = sat[15:0];
    w.inten = inten[13:0];
    w.br    = br[7:0];
    w.bg    = bg[7:0];
    w.bb    = bb[7:0];
    w.err   = 10'(labs(r - br) + labs(g - bg) + labs(b - bb));
    return w;
  endfunction

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_round_trip(r, g, b));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        hsi_word_t got, exp_w;
        got = m_axis_tdata[78:0];
        if (expected_q.size() == 0) begin
          $display("%0t unexpected word %h", $time, got);
          fails++;
        end else begin
          exp_w = expected_q.pop_front();
          if (got !== exp_w) begin
            $display("%0t mismatch expected %h actual %h", $time, exp_w, got);
            fails++;
          end
        end
      end
      m_axis_tready <= (snk_idle == 0) || ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic test_extremes();
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(10, 50, 50);
    send_pixel(200, 50, 50);
    send_pixel(100, 50, 150);
    send_pixel(100, 150, 50);
    send_pixel(255, 0, 1);
    send_pixel(255, 1, 0);
    send_pixel(1, 0, 0);
    send_pixel(254, 255, 255);
    send_pixel(170, 85, 170);
    send_pixel(85, 170, 85);
    send_pixel(8'h55, 8'haa, 8'h55);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          logic [7:0] v;
          v = 8'($urandom);
          send_pixel(v, v, v);
        end
        1: begin
          logic [7:0] r, v;
          r = 8'($urandom); v = 8'($urandom);
          send_pixel(r, v, v);
        end
        default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic test_pause();
    wait_drained();
    send_pixel(255, 0, 128);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle = 7; snk_idle = 77;
    test_extremes();
    test_random(500);
    test_pause();
    src_idle = 77; snk_idle = 7;
    test_random(500);
    src_idle = 0; snk_idle = 0;
    test_random(600);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
